>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL. Under SYNTHESIS they
// expand to nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/ldq_pkg.sv
// ---------------------------------------------------------------------------
// Linked deque package
// Request kinds, result status codes and fixed field widths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldq_pkg;

    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND_BACK = 3'd0,
        KIND_ADD_FRONT   = 3'd1,
        KIND_DROP_BACK   = 3'd2,
        KIND_DROP_FRONT  = 3'd3,
        KIND_REMOVE      = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

>>> hw/rtl/linked_deque_with_remove.sv
// ---------------------------------------------------------------------------
// Linked deque with remove by value
// Bounded doubly linked list of signed 32-bit values kept in a node memory,
// with push and pop at both ends and unlink of the first matching value.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Handshake
//  -------   ---------  ---------------------------------------  ----------------
//  s_axis    in         tdata: value[31:0]; tuser: kind[2:0]      tvalid & tready
//  m_axis    out        tdata: status[1:0], count[6:2], 0[7]      tvalid & tready
//
// Steps per item, from acceptance to the result register:
//   full, empty or unused request: straight to the result step.
//   append back / add front : a freed slot is first popped from the free stack
//                             when one exists, and a neighbor link is written
//                             before the new node when the list was not empty.
//   drop back / drop front  : read the end node, then unlink it.
//   remove by value         : walk from the front to the first match, then unlink
//                             it, with an extra step for an inner entry; an absent
//                             value ends the walk at the last entry. The walk reads
//                             one node per cycle through the node memory read port.
// Reset is synchronous and clears only control state; the memories need no
// clearing pass, since slots come from a fresh counter or the free stack.
// The block takes a new item while a result still waits on m_axis; it stalls
// in its final step only until the result register is free.
//
`timescale 1ns / 1ps

`include "assert_macros.svh"

module linked_deque_with_remove #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic signed [ldq_pkg::VALUE_W-1:0]  i_s_axis_tdata,  // value[31:0]
    input  logic [ldq_pkg::KIND_W-1:0]          i_s_axis_tuser,  // kind[2:0]
    // Result channel.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [ldq_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata   // status[1:0], count[6:2]
);

    // Slot index width and entry count width.
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef struct packed {
        logic [ldq_pkg::VALUE_W-1:0] val;
        logic [SW-1:0]               nxt;
        logic [SW-1:0]               prv;
    } t_node;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_ADD1,
        S_ADD2,
        S_READ,
        S_WALK,
        S_UNL1,
        S_UNL2,
        S_DONE
    } t_state;

    // Node memory: value plus both links, with a write enable per field.
    t_node          r_node_mem [CAPACITY];
    t_node          r_nd_rdata;
    // Free stack of released slots.
    logic [SW-1:0]  r_stk_mem [CAPACITY];
    logic [SW-1:0]  r_stk_rdata;

    // Control state.
    t_state         r_state, n_state;
    logic [SW-1:0]  r_first, n_first;
    logic [SW-1:0]  r_last, n_last;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_stk_cnt, n_stk_cnt;
    logic [CW-1:0]  r_fresh, n_fresh;
    logic           r_out_valid, n_out_valid;

    // Per-item working registers.
    logic [ldq_pkg::VALUE_W-1:0] r_value, n_value;
    logic                        r_front, n_front;
    logic [SW-1:0]               r_slot, n_slot;
    logic [SW-1:0]               r_nxt, n_nxt;
    logic [SW-1:0]               r_prv, n_prv;
    logic [CW-1:0]               r_idx, n_idx;
    ldq_pkg::t_status            r_status, n_status;
    ldq_pkg::t_status            r_out_status, n_out_status;
    logic [ldq_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    // Memory access controls.
    logic                        nd_rd_en;
    logic [SW-1:0]               nd_rd_addr;
    logic                        nd_we_val, nd_we_nxt, nd_we_prv;
    logic [SW-1:0]               nd_wr_addr;
    logic [ldq_pkg::VALUE_W-1:0] nd_wr_val;
    logic [SW-1:0]               nd_wr_nxt, nd_wr_prv;
    logic                        stk_we, stk_re;
    logic [CW-1:0]               stk_top;
    logic [SW-1:0]               stk_rd_addr;

    logic                        in_accept;
    logic                        release_slot;
    ldq_pkg::t_kind              in_kind;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_kind         = ldq_pkg::t_kind'(i_s_axis_tuser);
    assign stk_top         = r_stk_cnt - 1'b1;
    assign stk_rd_addr     = stk_top[SW-1:0];

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_out_status};

    always_comb begin
        n_state      = r_state;
        n_first      = r_first;
        n_last       = r_last;
        n_count      = r_count;
        n_stk_cnt    = r_stk_cnt;
        n_fresh      = r_fresh;
        n_value      = r_value;
        n_front      = r_front;
        n_slot       = r_slot;
        n_nxt        = r_nxt;
        n_prv        = r_prv;
        n_idx        = r_idx;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid && !i_m_axis_tready;

        nd_rd_en     = 1'b0;
        nd_rd_addr   = r_first;
        nd_we_val    = 1'b0;
        nd_we_nxt    = 1'b0;
        nd_we_prv    = 1'b0;
        nd_wr_addr   = r_slot;
        nd_wr_val    = r_value;
        nd_wr_nxt    = r_slot;
        nd_wr_prv    = r_slot;
        stk_re       = 1'b0;
        release_slot = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_value  = i_s_axis_tdata;
                    n_front  = (in_kind == ldq_pkg::KIND_ADD_FRONT) ||
                               (in_kind == ldq_pkg::KIND_DROP_FRONT);
                    n_status = ldq_pkg::ST_OK;
                    unique case (in_kind) inside
                        ldq_pkg::KIND_APPEND_BACK, ldq_pkg::KIND_ADD_FRONT: begin
                            if (r_count == CAP_C) begin
                                n_status = ldq_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_stk_cnt != '0) begin
                                stk_re  = 1'b1;
                                n_state = S_POP;
                            end else begin
                                n_slot  = r_fresh[SW-1:0];
                                n_fresh = r_fresh + 1'b1;
                                n_state = S_ADD1;
                            end
                        end
                        ldq_pkg::KIND_DROP_BACK, ldq_pkg::KIND_DROP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ldq_pkg::ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_slot     = n_front ? r_first : r_last;
                                nd_rd_en   = 1'b1;
                                nd_rd_addr = n_slot;
                                n_state    = S_READ;
                            end
                        end
                        ldq_pkg::KIND_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ldq_pkg::ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_slot     = r_first;
                                n_idx      = '0;
                                nd_rd_en   = 1'b1;
                                nd_rd_addr = r_first;
                                n_state    = S_WALK;
                            end
                        end
                        default: begin
                            // Unused kinds change nothing and report ok.
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_POP: begin
                n_slot    = r_stk_rdata;
                n_stk_cnt = r_stk_cnt - 1'b1;
                n_state   = S_ADD1;
            end

            S_ADD1: begin
                if (r_count == '0) begin
                    // First entry links to itself at both ends.
                    nd_we_val  = 1'b1;
                    nd_we_nxt  = 1'b1;
                    nd_we_prv  = 1'b1;
                    nd_wr_addr = r_slot;
                    n_first    = r_slot;
                    n_last     = r_slot;
                    n_count    = r_count + 1'b1;
                    n_state    = S_DONE;
                end else if (r_front) begin
                    nd_we_prv  = 1'b1;
                    nd_wr_addr = r_first;
                    nd_wr_prv  = r_slot;
                    n_state    = S_ADD2;
                end else begin
                    nd_we_nxt  = 1'b1;
                    nd_wr_addr = r_last;
                    nd_wr_nxt  = r_slot;
                    n_state    = S_ADD2;
                end
            end

            S_ADD2: begin
                nd_we_val  = 1'b1;
                nd_we_nxt  = 1'b1;
                nd_we_prv  = 1'b1;
                nd_wr_addr = r_slot;
                nd_wr_nxt  = r_front ? r_first : r_slot;
                nd_wr_prv  = r_front ? r_slot : r_last;
                if (r_front) begin
                    n_first = r_slot;
                end else begin
                    n_last = r_slot;
                end
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end

            S_READ: begin
                n_nxt   = r_nd_rdata.nxt;
                n_prv   = r_nd_rdata.prv;
                n_state = S_UNL1;
            end

            S_WALK: begin
                if (r_nd_rdata.val == r_value) begin
                    n_nxt   = r_nd_rdata.nxt;
                    n_prv   = r_nd_rdata.prv;
                    n_state = S_UNL1;
                end else if (CW'(r_idx + 1'b1) == r_count) begin
                    n_status = ldq_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx      = r_idx + 1'b1;
                    n_slot     = r_nd_rdata.nxt;
                    nd_rd_en   = 1'b1;
                    nd_rd_addr = r_nd_rdata.nxt;
                end
            end

            S_UNL1: begin
                release_slot = 1'b1;
                n_state      = S_DONE;
                if (r_count == CW'(1)) begin
                    n_first = '0;
                    n_last  = '0;
                end else if (r_slot == r_first) begin
                    // New head points back to itself.
                    nd_we_prv  = 1'b1;
                    nd_wr_addr = r_nxt;
                    nd_wr_prv  = r_nxt;
                    n_first    = r_nxt;
                end else if (r_slot == r_last) begin
                    nd_we_nxt  = 1'b1;
                    nd_wr_addr = r_prv;
                    nd_wr_nxt  = r_prv;
                    n_last     = r_prv;
                end else begin
                    // Inner entry: bridge the predecessor now, the successor next.
                    release_slot = 1'b0;
                    nd_we_nxt    = 1'b1;
                    nd_wr_addr   = r_prv;
                    nd_wr_nxt    = r_nxt;
                    n_state      = S_UNL2;
                end
            end

            S_UNL2: begin
                nd_we_prv    = 1'b1;
                nd_wr_addr   = r_nxt;
                nd_wr_prv    = r_prv;
                release_slot = 1'b1;
                n_state      = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = ldq_pkg::COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A released slot goes onto the free stack and the count drops.
        stk_we = release_slot;
        if (release_slot) begin
            n_stk_cnt = r_stk_cnt + 1'b1;
            n_count   = r_count - 1'b1;
        end
    end

    // Node memory, one read and one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (nd_we_val) begin
            r_node_mem[nd_wr_addr].val <= nd_wr_val;
        end
        if (nd_we_nxt) begin
            r_node_mem[nd_wr_addr].nxt <= nd_wr_nxt;
        end
        if (nd_we_prv) begin
            r_node_mem[nd_wr_addr].prv <= nd_wr_prv;
        end
        if (nd_rd_en) begin
            r_nd_rdata <= r_node_mem[nd_rd_addr];
        end
    end

    // Free stack memory. A push never shares a cycle with a pop.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[r_stk_cnt[SW-1:0]] <= r_slot;
        end
        if (stk_re) begin
            r_stk_rdata <= r_stk_mem[stk_rd_addr];
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_stk_cnt   <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_last      <= n_last;
            r_count     <= n_count;
            r_stk_cnt   <= n_stk_cnt;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
        r_value      <= n_value;
        r_front      <= n_front;
        r_slot       <= n_slot;
        r_nxt        <= n_nxt;
        r_prv        <= n_prv;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    // Every slot is either live, on the free stack, or not yet handed out.
    `ASSERT_IMPLIES(a_slot_accounting, i_clk, i_rst_n, r_state == S_IDLE, (CW+1)'(r_count) + (CW+1)'(r_stk_cnt) == (CW+1)'(r_fresh))
    // The entry count never goes past the capacity.
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CAP_C)
    // Every accepted item leaves the idle state in the following cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_accept, r_state != S_IDLE)
    // A full status is reported only with a full list.
    `ASSERT_IMPLIES(a_full_status, i_clk, i_rst_n, r_state == S_DONE && r_status == ldq_pkg::ST_FULL, r_count == CAP_C)

endmodule
